FILE: hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes for the buddy block allocator: datapath operation
// codes, result status codes, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_BLOCK  = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd2;
  localparam logic [1:0] ST_BAD_ADDR  = 2'd3;

  // Leaf record layout: valid bit over a 4-bit order
  localparam int REC_W     = 5;
  localparam int REC_ORD_W = 4;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLR,
    DP_LOAD,
    DP_SCAN_RD,
    DP_SCAN_NEXT,
    DP_WR_FOUND,
    DP_SPLIT_DOWN,
    DP_WR_RIGHT,
    DP_WR_REC,
    DP_DIV_STEP,
    DP_REC_RD,
    DP_FREE_SET,
    DP_BUD_RD,
    DP_MERGE_A,
    DP_MERGE_B,
    DP_MERGE_UP,
    DP_RES
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] stat;      // status to post with DP_RES
    logic       use_addr;  // post the block address with DP_RES
  } bba_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic size_bad;
    logic range_bad;
    logic rd_bit;
    logic scan_last;
    logic from_zero;
    logic from_lt_order;
    logic rem_nz;
    logic rec_ok;
  } bba_sts_t;

endpackage

FILE: hdl/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp
// Allocator datapath: free-mark and leaf-record memories, scan and split/merge
// cursors, offset divider, address arithmetic and result registers.
// ----------------------------------------------------------------------------
module bba_dp import bba_pkg::*; #(
  parameter int LEVELS          = 11,
  parameter int MIN_BLOCK_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bba_cmd_t    cmd_i,
  output bba_sts_t    sts_o,
  input  logic        cfg_we_i,
  input  logic [47:0] cfg_data_i,
  input  logic        operation_i,
  input  logic [14:0] request_bytes_i,
  input  logic [47:0] free_address_i,
  output logic [47:0] block_address_o,
  output logic [1:0]  status_o
);

  localparam int TOP    = LEVELS - 1;
  localparam int OW     = $clog2(LEVELS);
  localparam int IW     = TOP;
  localparam int NW     = LEVELS;
  localparam int NODES  = (1 << LEVELS) - 1;
  localparam int LEAVES = 1 << TOP;
  localparam int RW     = LEVELS + $clog2(MIN_BLOCK_BYTES) + 1;
  localparam logic [47:0] POOL_BYTES = 48'(MIN_BLOCK_BYTES) << TOP;
  // Reciprocal division of an in-range offset by the smallest block size
  localparam int MBW    = $clog2(MIN_BLOCK_BYTES);
  localparam int DN     = TOP + MBW;     // offset bits once range is checked
  localparam int DS     = DN + MBW;      // reciprocal shift
  localparam int PW     = 2 * DN + 1;    // reciprocal product width
  localparam longint unsigned RECIP =
    ((64'd1 << DS) + 64'(MIN_BLOCK_BYTES) - 64'd1) / 64'(MIN_BLOCK_BYTES);

  function automatic logic [NW-1:0] node_at(logic [OW-1:0] o, logic [IW-1:0] i);
    node_at = ((NW'(1) << o) - NW'(1)) + NW'(i);
  endfunction

  // Registers
  logic [47:0]     pool_q;
  logic [NW-1:0]   clr_q;
  logic            is_free_q, size_bad_q, range_bad_q;
  logic [OW-1:0]   order_q, from_q;
  logic [IW-1:0]   idx_q, leaf_q;
  logic [RW-1:0]   rem_q, prod_q;
  logic            rd_q;
  logic [REC_W-1:0] rec_q;
  logic [47:0]     addr_q;
  logic [1:0]      stat_q;

  // Memories
  logic             node_mem [NODES];
  logic [REC_W-1:0] rec_mem  [LEAVES];

  // Request order: largest order whose block still holds the request
  logic [OW-1:0] req_ord;
  logic          fit_any;
  always_comb begin
    req_ord = '0;
    fit_any = 1'b0;
    for (int o = 0; o < LEVELS; o++) begin
      if (32'(request_bytes_i) <= (32'(MIN_BLOCK_BYTES) << (TOP - o))) begin
        req_ord = OW'(o);
        fit_any = 1'b1;
      end
    end
  end

  logic [47:0]   free_off;
  logic [OW-1:0] rec_ord;
  logic [IW-1:0] rec_idx, alloc_leaf;
  logic [PW-1:0] quo_prod;
  logic [RW-1:0] leaf_bytes;
  assign free_off   = free_address_i - pool_q;
  assign rec_ord    = OW'(rec_q[REC_ORD_W-1:0]);
  assign rec_idx    = IW'(leaf_q >> (REC_ORD_W'(TOP) - rec_q[REC_ORD_W-1:0]));
  assign alloc_leaf = IW'(idx_q << (OW'(TOP) - order_q));
  assign quo_prod   = PW'(rem_q[DN-1:0]) * PW'(RECIP);
  assign leaf_bytes = RW'(leaf_q) * RW'(MIN_BLOCK_BYTES);

  // Memory port controls
  logic          n_we, n_wd, n_re, r_we, r_re;
  logic [NW-1:0] n_wa, n_ra;
  logic [IW-1:0] r_wa;
  logic [REC_W-1:0] r_wd;
  always_comb begin
    n_we = 1'b0; n_wd = 1'b0; n_wa = node_at(from_q, idx_q);
    n_re = 1'b0; n_ra = node_at(from_q, idx_q);
    r_we = 1'b0; r_wa = leaf_q; r_wd = '0; r_re = 1'b0;
    unique case (cmd_i.op)
      DP_CLR: begin
        n_we = 1'b1; n_wa = clr_q; n_wd = (clr_q == '0);
        r_we = ~clr_q[NW-1]; r_wa = clr_q[IW-1:0];
      end
      DP_SCAN_RD:    n_re = 1'b1;
      DP_WR_FOUND:   n_we = 1'b1;
      DP_SPLIT_DOWN: begin
        n_we = 1'b1; n_wa = node_at(from_q + OW'(1), IW'({idx_q, 1'b0}));
      end
      DP_WR_RIGHT: begin
        n_we = 1'b1; n_wd = 1'b1; n_wa = node_at(from_q, idx_q | IW'(1));
      end
      DP_WR_REC: begin
        r_we = 1'b1; r_wa = alloc_leaf;
        r_wd = {1'b1, REC_ORD_W'(order_q)};
      end
      DP_REC_RD:   r_re = 1'b1;
      DP_FREE_SET: begin
        r_we = 1'b1; n_we = 1'b1; n_wd = 1'b1; n_wa = node_at(rec_ord, rec_idx);
      end
      DP_BUD_RD: begin
        n_re = 1'b1; n_ra = node_at(from_q, idx_q ^ IW'(1));
      end
      DP_MERGE_A:  n_we = 1'b1;
      DP_MERGE_B: begin
        n_we = 1'b1; n_wa = node_at(from_q, idx_q ^ IW'(1));
      end
      DP_MERGE_UP: begin
        n_we = 1'b1; n_wd = 1'b1; n_wa = node_at(from_q - OW'(1), idx_q >> 1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (n_we) node_mem[n_wa] <= n_wd;
    if (n_re) rd_q <= node_mem[n_ra];
    if (r_we) rec_mem[r_wa] <= r_wd;
    if (r_re) rec_q <= rec_mem[leaf_q];
  end

  // Control registers: pool base and clearing counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= '0;
      clr_q  <= '0;
    end else begin
      if (cfg_we_i) pool_q <= cfg_data_i;
      if (cmd_i.op == DP_CLR) clr_q <= clr_q + NW'(1);
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LOAD: begin
        is_free_q   <= operation_i;
        order_q     <= req_ord;
        from_q      <= req_ord;
        idx_q       <= '0;
        size_bad_q  <= (request_bytes_i == '0) || !fit_any;
        range_bad_q <= (free_off >= POOL_BYTES);
        rem_q       <= RW'(free_off);
        leaf_q      <= '0;
      end
      DP_SCAN_NEXT: begin
        if (sts_o.scan_last) begin
          from_q <= from_q - OW'(1);
          idx_q  <= '0;
        end else begin
          idx_q <= idx_q + IW'(1);
        end
      end
      DP_SPLIT_DOWN: begin
        from_q <= from_q + OW'(1);
        idx_q  <= IW'({idx_q, 1'b0});
      end
      DP_WR_REC: prod_q <= RW'(RW'(alloc_leaf) * RW'(MIN_BLOCK_BYTES));
      // Leaf index by reciprocal multiply; exact for every in-range offset
      DP_DIV_STEP: leaf_q <= IW'(quo_prod >> DS);
      DP_FREE_SET: begin
        from_q <= rec_ord;
        idx_q  <= rec_idx;
      end
      DP_MERGE_UP: begin
        from_q <= from_q - OW'(1);
        idx_q  <= idx_q >> 1;
      end
      DP_RES: begin
        addr_q <= cmd_i.use_addr ? (pool_q + 48'(prod_q)) : '0;
        stat_q <= cmd_i.stat;
      end
      default: ;
    endcase
  end

  // Status to the controller
  assign sts_o.clr_done      = (clr_q == NW'(NODES - 1));
  assign sts_o.is_free       = is_free_q;
  assign sts_o.size_bad      = size_bad_q;
  assign sts_o.range_bad     = range_bad_q;
  assign sts_o.rd_bit        = rd_q;
  assign sts_o.scan_last     = (({1'b0, idx_q} + (IW+1)'(1)) == ((IW+1)'(1) << from_q));
  assign sts_o.from_zero     = (from_q == '0);
  assign sts_o.from_lt_order = (from_q < order_q);
  assign sts_o.rem_nz        = (rem_q != leaf_bytes);
  assign sts_o.rec_ok        = rec_q[REC_W-1] &&
                               (rec_q[REC_ORD_W-1:0] <= REC_ORD_W'(TOP));

  assign block_address_o = addr_q;
  assign status_o        = stat_q;

endmodule

FILE: hdl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Allocator controller: clearing pass, allocate scan and split sequence, free
// divide/lookup and merge sequence, and the result handshake.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bba_cmd_t cmd_o,
  input  bba_sts_t sts_i
);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_DEC  = 5'd2;
  localparam logic [4:0] S_SRD  = 5'd3;
  localparam logic [4:0] S_SCHK = 5'd4;
  localparam logic [4:0] S_TAKE = 5'd5;
  localparam logic [4:0] S_SPLA = 5'd6;
  localparam logic [4:0] S_SPLB = 5'd7;
  localparam logic [4:0] S_SREC = 5'd8;
  localparam logic [4:0] S_DIV  = 5'd9;
  localparam logic [4:0] S_DCHK = 5'd10;
  localparam logic [4:0] S_RCHK = 5'd11;
  localparam logic [4:0] S_BRD  = 5'd12;
  localparam logic [4:0] S_BCHK = 5'd13;
  localparam logic [4:0] S_MB   = 5'd14;
  localparam logic [4:0] S_MUP  = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  logic [4:0] state_q, state_d;
  logic [1:0] rstat_q, rstat_d;
  logic       raddr_q, raddr_d;
  logic       oval_q, oval_d;
  logic       out_free;

  assign out_free = !oval_q || out_ready_i;

  // Next state and datapath command
  always_comb begin
    state_d = state_q;
    rstat_d = rstat_q;
    raddr_d = raddr_q;
    oval_d  = oval_q && !out_ready_i;
    cmd_o   = '{op: DP_NOP, stat: rstat_q, use_addr: raddr_q};
    unique case (state_q)
      S_CLR: begin
        cmd_o.op = DP_CLR;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        raddr_d = 1'b0;
        if (sts_i.is_free) begin
          if (sts_i.range_bad) begin
            rstat_d = ST_BAD_ADDR; state_d = S_OUT;
          end else begin
            state_d = S_DIV;
          end
        end else if (sts_i.size_bad) begin
          rstat_d = ST_BAD_SIZE; state_d = S_OUT;
        end else begin
          state_d = S_SRD;
        end
      end
      // Allocate: scan marks of one order, then move to lower orders (larger blocks)
      S_SRD: begin
        cmd_o.op = DP_SCAN_RD;
        state_d  = S_SCHK;
      end
      S_SCHK: begin
        if (sts_i.rd_bit) begin
          state_d = S_TAKE;
        end else if (sts_i.scan_last && sts_i.from_zero) begin
          rstat_d = ST_NO_BLOCK; state_d = S_OUT;
        end else begin
          cmd_o.op = DP_SCAN_NEXT; state_d = S_SRD;
        end
      end
      S_TAKE: begin
        cmd_o.op = DP_WR_FOUND;
        state_d  = sts_i.from_lt_order ? S_SPLA : S_SREC;
      end
      S_SPLA: begin
        cmd_o.op = DP_SPLIT_DOWN;
        state_d  = S_SPLB;
      end
      S_SPLB: begin
        cmd_o.op = DP_WR_RIGHT;
        state_d  = sts_i.from_lt_order ? S_SPLA : S_SREC;
      end
      S_SREC: begin
        cmd_o.op = DP_WR_REC;
        rstat_d  = ST_OK;
        raddr_d  = 1'b1;
        state_d  = S_OUT;
      end
      // Free: offset to leaf, record lookup, merge upward
      S_DIV: begin
        cmd_o.op = DP_DIV_STEP;
        state_d  = S_DCHK;
      end
      S_DCHK: begin
        if (sts_i.rem_nz) begin
          rstat_d = ST_BAD_ADDR; state_d = S_OUT;
        end else begin
          cmd_o.op = DP_REC_RD; state_d = S_RCHK;
        end
      end
      S_RCHK: begin
        if (!sts_i.rec_ok) begin
          rstat_d = ST_BAD_ADDR; state_d = S_OUT;
        end else begin
          cmd_o.op = DP_FREE_SET; state_d = S_BRD;
        end
      end
      S_BRD: begin
        if (sts_i.from_zero) begin
          rstat_d = ST_OK; state_d = S_OUT;
        end else begin
          cmd_o.op = DP_BUD_RD; state_d = S_BCHK;
        end
      end
      S_BCHK: begin
        if (sts_i.rd_bit) begin
          cmd_o.op = DP_MERGE_A; state_d = S_MB;
        end else begin
          rstat_d = ST_OK; state_d = S_OUT;
        end
      end
      S_MB: begin
        cmd_o.op = DP_MERGE_B;
        state_d  = S_MUP;
      end
      S_MUP: begin
        cmd_o.op = DP_MERGE_UP;
        state_d  = S_BRD;
      end
      // Post the result once the output register is free
      S_OUT: begin
        if (out_free) begin
          cmd_o.op = DP_RES;
          oval_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      rstat_q <= ST_OK;
      raddr_q <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rstat_q <= rstat_d;
      raddr_q <= raddr_d;
      oval_q  <= oval_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = oval_q;

endmodule

FILE: hdl/buddy_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Binary buddy allocator over 2^(LEVELS-1) smallest blocks of MIN_BLOCK_BYTES.
// Allocates and frees blocks; one result transaction per request transaction.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+----
//  in      | in_valid_i/in_ready_o, operation_i,       | in
//          | request_bytes_i, free_address_i           |
//  out     | out_valid_o/out_ready_i, block_address_o, | out
//          | status_o                                  |
//  cfg     | cfg_we_i, cfg_data_i (pool base)          | in
//
//  One request at a time. Allocate: scan free marks (one node memory read
//  port), then split level by level. Free: one divide step, a record lookup,
//  then merge level by level.
//  After reset a clearing pass runs before in_ready_o.
//  The output register holds a finished result while the next request is taken.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit import bba_pkg::*; #(
  parameter int LEVELS          = 11,
  parameter int MIN_BLOCK_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [14:0] request_bytes_i,
  input  logic [47:0] free_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] block_address_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [47:0] cfg_data_i
);

  bba_cmd_t cmd;
  bba_sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bba_dp #(
    .LEVELS          (LEVELS),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .request_bytes_i (request_bytes_i),
    .free_address_i  (free_address_i),
    .block_address_o (block_address_o),
    .status_o        (status_o)
  );

endmodule
